/* hw/rtl/dva_pkg.sv */
// shared types, constants, calendar helpers and microcode for the date validate and age block
package dva_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 8;
    localparam int DAY_W   = 8;
    localparam int DOY_W   = 9;
    localparam int MLEN_W  = 5;
    localparam int MON_W   = 4;
    localparam int PC_W    = 4;

    localparam int AGE_Y_W = 13;
    localparam int AGE_M_W = 4;
    localparam int AGE_D_W = 5;

    // inverse of 25 modulo 2**YEAR_W and the divisibility bound (2**YEAR_W - 1) / 25
    localparam logic [YEAR_W-1:0] INV25     = 12'd3113;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 12'd163;

    localparam logic [MON_W-1:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [MON_W-1:0]  FEBRUARY        = 4'd2;
    localparam logic [DOY_W-1:0]  LEAP_YEAR_LEN   = 9'd366;
    localparam logic [DOY_W-1:0]  COMMON_YEAR_LEN = 9'd365;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_YEAR_ZERO   = 3'd1,
        ST_MONTH_RANGE = 3'd2,
        ST_DAY_LOW     = 3'd3,
        ST_DAY_HIGH    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_LEAP_B,
        OP_LEAP_C,
        OP_CHECK,
        OP_CLAMP,
        OP_WALK,
        OP_SUB,
        OP_BORROW_D,
        OP_BORROW_M,
        OP_SAT,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_START,
        COND_ERR,
        COND_WALK,
        COND_OUT
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic out_free;
        logic err;
        logic walk;
    } seq_flags_t;

    typedef struct packed {
        logic err;
        logic walk;
    } dp_flags_t;

    typedef struct packed {
        logic [DOY_W-1:0]   current_day_of_year;
        logic [YEAR_W-1:0]  current_year;
        logic [DAY_W-1:0]   birth_day;
        logic [MONTH_W-1:0] birth_month;
        logic [YEAR_W-1:0]  birth_year;
    } in_item_t;

    typedef struct packed {
        logic [AGE_D_W-1:0]        age_days;
        logic [AGE_M_W-1:0]        age_months;
        logic signed [AGE_Y_W-1:0] age_years;
        status_t                   status;
    } out_item_t;

    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
    localparam logic [PC_W-1:0] PC_OUT  = 4'd10;

    function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [MLEN_W-1:0] len;
        case (m)
            FEBRUARY:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            4'd0:    w = '{op: OP_LOAD,     cond: COND_START, target: PC_IDLE};
            4'd1:    w = '{op: OP_LEAP_B,   cond: COND_NEXT,  target: PC_IDLE};
            4'd2:    w = '{op: OP_LEAP_C,   cond: COND_NEXT,  target: PC_IDLE};
            4'd3:    w = '{op: OP_CHECK,    cond: COND_ERR,   target: PC_OUT};
            4'd4:    w = '{op: OP_CLAMP,    cond: COND_NEXT,  target: PC_IDLE};
            4'd5:    w = '{op: OP_WALK,     cond: COND_WALK,  target: PC_IDLE};
            4'd6:    w = '{op: OP_SUB,      cond: COND_NEXT,  target: PC_IDLE};
            4'd7:    w = '{op: OP_BORROW_D, cond: COND_NEXT,  target: PC_IDLE};
            4'd8:    w = '{op: OP_BORROW_M, cond: COND_NEXT,  target: PC_IDLE};
            4'd9:    w = '{op: OP_SAT,      cond: COND_NEXT,  target: PC_IDLE};
            4'd10:   w = '{op: OP_OUT,      cond: COND_OUT,   target: PC_IDLE};
            default: w = '{op: OP_LOAD,     cond: COND_START, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/dva_seq.sv */
// step counter and microcode table with conditional jumps
module dva_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  dva_pkg::seq_flags_t flags,
    output dva_pkg::ctrl_word_t ctrl
);

    logic [dva_pkg::PC_W-1:0] pc_reg;
    logic [dva_pkg::PC_W-1:0] pc_next;
    logic [dva_pkg::PC_W-1:0] pc_inc;

    assign ctrl   = dva_pkg::ucode(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    always_comb
    begin
        pc_next = pc_inc;
        case (ctrl.cond)
            dva_pkg::COND_NEXT:  pc_next = pc_inc;
            dva_pkg::COND_START: pc_next = flags.start ? pc_inc : pc_reg;
            dva_pkg::COND_ERR:   pc_next = flags.err ? ctrl.target : pc_inc;
            dva_pkg::COND_WALK:  pc_next = flags.walk ? pc_reg : pc_inc;
            dva_pkg::COND_OUT:   pc_next = flags.out_free ? ctrl.target : pc_reg;
            default:             pc_next = dva_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= dva_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hw/rtl/dva_datapath.sv */
// working registers, leap year unit, date checks, month walk and borrow arithmetic
module dva_datapath
#(
    parameter int unsigned MAX_YEAR = 4095
)
(
    input  logic                clk,
    input  dva_pkg::ctrl_word_t ctrl,
    input  logic                load,
    input  dva_pkg::in_item_t   item,
    output dva_pkg::dp_flags_t  flags,
    output dva_pkg::out_item_t  result
);

    localparam int SAT_W = 18;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(MAX_YEAR);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(MAX_YEAR);

    logic [dva_pkg::YEAR_W-1:0]  by_reg, cy_reg;
    logic [dva_pkg::MONTH_W-1:0] bm_reg;
    logic [dva_pkg::DAY_W-1:0]   bd_reg;
    logic [dva_pkg::DOY_W-1:0]   doy_reg;
    logic                        leap_b_reg, leap_b_next;
    logic                        leap_c_reg, leap_c_next;
    dva_pkg::status_t            status_reg, status_next;
    logic [dva_pkg::DOY_W-1:0]   left_reg, left_next;
    logic [dva_pkg::MON_W-1:0]   cm_reg, cm_next;
    logic signed [6:0]           days_reg, days_next;
    logic signed [4:0]           months_reg, months_next;
    logic signed [13:0]          years_reg, years_next;

    logic [dva_pkg::YEAR_W-1:0]   leap_year;
    logic [2*dva_pkg::YEAR_W-1:0] leap_prod;
    logic                         leap_res;
    logic [dva_pkg::MLEN_W-1:0]   mlen_b, mlen_c;
    logic [dva_pkg::DOY_W-1:0]    ylen;
    dva_pkg::status_t             check;
    logic signed [SAT_W-1:0]      years_wide;

    // divisible by 25 when y * inverse mod 2**n does not exceed the bound; leap = 4 and (not 100 or 400)
    assign leap_year = (ctrl.op == dva_pkg::OP_LEAP_C) ? cy_reg : by_reg;
    assign leap_prod = {{dva_pkg::YEAR_W{1'b0}}, leap_year}
                     * {{dva_pkg::YEAR_W{1'b0}}, dva_pkg::INV25};
    assign leap_res  = (leap_year[1:0] == 2'd0)
                     && ((leap_prod[dva_pkg::YEAR_W-1:0] > dva_pkg::DIV25_LIM)
                         || (leap_year[3:0] == 4'd0));

    assign mlen_b = dva_pkg::month_len(bm_reg[dva_pkg::MON_W-1:0], leap_b_reg);
    assign mlen_c = dva_pkg::month_len(cm_reg, leap_c_reg);
    assign ylen   = leap_c_reg ? dva_pkg::LEAP_YEAR_LEN : dva_pkg::COMMON_YEAR_LEN;

    always_comb
    begin
        if (by_reg == '0)
            check = dva_pkg::ST_YEAR_ZERO;
        else if (bm_reg == '0 || bm_reg > {4'd0, dva_pkg::MONTHS_PER_YEAR})
            check = dva_pkg::ST_MONTH_RANGE;
        else if (bd_reg == '0)
            check = dva_pkg::ST_DAY_LOW;
        else if (bd_reg > {3'd0, mlen_b})
            check = dva_pkg::ST_DAY_HIGH;
        else
            check = dva_pkg::ST_OK;
    end

    assign flags.err  = (check != dva_pkg::ST_OK);
    assign flags.walk = (cm_reg < dva_pkg::MONTHS_PER_YEAR) && (left_reg > {4'd0, mlen_c});

    assign years_wide = {{(SAT_W-14){years_reg[13]}}, years_reg};

    always_comb
    begin
        leap_b_next = leap_b_reg;
        leap_c_next = leap_c_reg;
        status_next = status_reg;
        left_next   = left_reg;
        cm_next     = cm_reg;
        days_next   = days_reg;
        months_next = months_reg;
        years_next  = years_reg;
        case (ctrl.op)
            dva_pkg::OP_LEAP_B: leap_b_next = leap_res;
            dva_pkg::OP_LEAP_C: leap_c_next = leap_res;
            dva_pkg::OP_CHECK:  status_next = check;
            dva_pkg::OP_CLAMP:
            begin
                cm_next = 4'd1;
                if (doy_reg == '0)
                    left_next = 9'd1;
                else if (doy_reg > ylen)
                    left_next = ylen;
                else
                    left_next = doy_reg;
            end
            dva_pkg::OP_WALK:
            begin
                if (flags.walk)
                begin
                    left_next = left_reg - {4'd0, mlen_c};
                    cm_next   = cm_reg + 1'b1;
                end
            end
            dva_pkg::OP_SUB:
            begin
                days_next   = $signed({2'b00, left_reg[4:0]}) - $signed({2'b00, bd_reg[4:0]});
                months_next = $signed({1'b0, cm_reg})
                            - $signed({1'b0, bm_reg[dva_pkg::MON_W-1:0]});
                years_next  = $signed({2'b00, cy_reg}) - $signed({2'b00, by_reg});
            end
            dva_pkg::OP_BORROW_D:
            begin
                // day borrow takes the length of the birth month
                if (days_reg < 0)
                begin
                    months_next = months_reg - 5'sd1;
                    days_next   = days_reg + $signed({2'b00, mlen_b});
                end
            end
            dva_pkg::OP_BORROW_M:
            begin
                if (months_reg < 0)
                begin
                    years_next  = years_reg - 14'sd1;
                    months_next = months_reg + $signed({1'b0, dva_pkg::MONTHS_PER_YEAR});
                end
            end
            dva_pkg::OP_SAT:
            begin
                if (years_wide > SAT_HI)
                    years_next = SAT_HI[13:0];
                else if (years_wide < SAT_LO)
                    years_next = SAT_LO[13:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            by_reg  <= item.birth_year;
            bm_reg  <= item.birth_month;
            bd_reg  <= item.birth_day;
            cy_reg  <= item.current_year;
            doy_reg <= item.current_day_of_year;
        end
        leap_b_reg <= leap_b_next;
        leap_c_reg <= leap_c_next;
        status_reg <= status_next;
        left_reg   <= left_next;
        cm_reg     <= cm_next;
        days_reg   <= days_next;
        months_reg <= months_next;
        years_reg  <= years_next;
    end

    // invalid dates give zero age fields
    always_comb
    begin
        result.status = status_reg;
        if (status_reg == dva_pkg::ST_OK)
        begin
            result.age_years  = years_reg[dva_pkg::AGE_Y_W-1:0];
            result.age_months = months_reg[dva_pkg::AGE_M_W-1:0];
            result.age_days   = days_reg[dva_pkg::AGE_D_W-1:0];
        end
        else
        begin
            result.age_years  = '0;
            result.age_months = '0;
            result.age_days   = '0;
        end
    end

endmodule

/* hw/rtl/date_validate_and_age_core.sv */
// top level: stream ports, output register, sequencer and datapath
//
// birth date check and age calculation on the gregorian calendar
// input channel s_*: one item carries a birth date plus the current year and
// day of year; one result item per input item leaves on m_*
// the block takes an item when its microprogram sits at the idle step, then
// runs: two leap year steps, a date check, a clamp of the day of year, a
// month walk that passes one month per step and ends on a final compare,
// three subtract and borrow steps, a saturate step and the output step
// the time from acceptance to result of a valid date varies with the month
// walk; an invalid date jumps from the date check to the output step
// no new item is taken until the previous one passes the output step, and the
// next item can be accepted in the cycle after the output step;
// the result register may still hold the previous item while the next one is worked on
// if the receiver stalls, the result holds in m_tdata and the sequencer waits
// at its output step until the register frees, with s_tready low
// reset clears the step counter and the output valid flag; no memory to clear
module date_validate_and_age_core
#(
    parameter int unsigned MAX_YEAR = 4095
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // birth_year[11:0], birth_month[19:12], birth_day[27:20], current_year[39:28],
    // current_day_of_year[48:40], zero fill [55:49]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], age_years[15:3], age_months[19:16], age_days[24:20], zero fill [31:25]
    output logic [31:0] m_tdata
);

    dva_pkg::ctrl_word_t ctrl;
    dva_pkg::seq_flags_t seq_flags;
    dva_pkg::dp_flags_t  dp_flags;
    dva_pkg::in_item_t   item;
    dva_pkg::out_item_t  result;

    logic        in_fire;
    logic        out_free;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    assign item     = s_tdata[$bits(dva_pkg::in_item_t)-1:0];
    assign s_tready = (ctrl.op == dva_pkg::OP_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign seq_flags.start    = in_fire;
    assign seq_flags.out_free = out_free;
    assign seq_flags.err      = dp_flags.err;
    assign seq_flags.walk     = dp_flags.walk;

    dva_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (seq_flags),
        .ctrl  (ctrl)
    );

    dva_datapath
    #(
        .MAX_YEAR (MAX_YEAR)
    )
    u_datapath
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .load   (in_fire),
        .item   (item),
        .flags  (dp_flags),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (ctrl.op == dva_pkg::OP_OUT && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(32-$bits(dva_pkg::out_item_t)){1'b0}}, result};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* bench/tb.sv */
// testbench for date_validate_and_age_core: scoreboard class, stream drivers and monitor
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TAIL_CYCLES  = 40;
    localparam int IDLE_PCT     = 8;

    class age_board;
        dva_pkg::out_item_t awaited[$];
        int unsigned        faults;

        static function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int unsigned month_days(int unsigned m, int unsigned y);
            if (m == 2)
                return leap_year(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // birth date check, day of year to month and day, then subtract with borrows
        function dva_pkg::out_item_t age_of(dva_pkg::in_item_t it);
            dva_pkg::out_item_t r;
            int unsigned by, bm, bd, cy, doy, ylen, cm, left;
            int          years, months, days;
            r  = '0;
            by = it.birth_year;
            bm = it.birth_month;
            bd = it.birth_day;
            cy = it.current_year;
            doy = it.current_day_of_year;
            if (by == 0)
                r.status = dva_pkg::ST_YEAR_ZERO;
            else if (bm < 1 || bm > 12)
                r.status = dva_pkg::ST_MONTH_RANGE;
            else if (bd < 1)
                r.status = dva_pkg::ST_DAY_LOW;
            else if (bd > month_days(bm, by))
                r.status = dva_pkg::ST_DAY_HIGH;
            else
            begin
                ylen = leap_year(cy) ? 366 : 365;
                if (doy < 1)
                    doy = 1;
                if (doy > ylen)
                    doy = ylen;
                left = doy;
                cm = 1;
                while (cm < 12 && left > month_days(cm, cy))
                begin
                    left -= month_days(cm, cy);
                    cm++;
                end
                days   = int'(left) - int'(bd);
                months = int'(cm) - int'(bm);
                years  = int'(cy) - int'(by);
                if (days < 0)
                begin
                    months--;
                    days += int'(month_days(bm, by));
                end
                if (months < 0)
                begin
                    years--;
                    months += 12;
                end
                if (years > 4095)
                    years = 4095;
                if (years < -4095)
                    years = -4095;
                r.status     = dva_pkg::ST_OK;
                r.age_years  = years[dva_pkg::AGE_Y_W-1:0];
                r.age_months = months[dva_pkg::AGE_M_W-1:0];
                r.age_days   = days[dva_pkg::AGE_D_W-1:0];
            end
            return r;
        endfunction

        function void note_input(dva_pkg::in_item_t it);
            awaited.push_back(age_of(it));
        endfunction

        function void flag(string field, int want, int got);
            $display("%0t: mismatch on %s, expected %0d, got %0d", $time, field, want, got);
            faults++;
        endfunction

        function void check_result(dva_pkg::out_item_t got);
            dva_pkg::out_item_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result item, got %h", $time, got);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                flag("status", int'(want.status), int'(got.status));
            if (got.age_years !== want.age_years)
                flag("age_years", int'(want.age_years), int'(got.age_years));
            if (got.age_months !== want.age_months)
                flag("age_months", int'(want.age_months), int'(got.age_months));
            if (got.age_days !== want.age_days)
                flag("age_days", int'(want.age_days), int'(got.age_days));
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    age_board    board;
    bit          calm = 1'b0;
    int unsigned cycles = 0;

    date_validate_and_age_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(dva_pkg::out_item_t'(m_tdata[24:0]));

    task automatic send_item(input dva_pkg::in_item_t it);
        int unsigned gap;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(6, 1);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(it);
    endtask

    task automatic send_date(input int unsigned by, input int unsigned bm,
                             input int unsigned bd, input int unsigned cy,
                             input int unsigned doy);
        dva_pkg::in_item_t it;
        it.birth_year          = by[dva_pkg::YEAR_W-1:0];
        it.birth_month         = bm[dva_pkg::MONTH_W-1:0];
        it.birth_day           = bd[dva_pkg::DAY_W-1:0];
        it.current_year        = cy[dva_pkg::YEAR_W-1:0];
        it.current_day_of_year = doy[dva_pkg::DOY_W-1:0];
        send_item(it);
    endtask

    task automatic send_random_date();
        int unsigned pick, by, bm, bd, cy, doy;
        pick = $urandom_range(99);
        by = $urandom_range(4095, 1);
        bm = $urandom_range(12, 1);
        bd = $urandom_range(age_board::month_days(bm, by), 1);
        cy = ($urandom_range(1)) ? $urandom_range(4095, 0) : (by + $urandom_range(120)) % 4096;
        doy = $urandom_range(366, 1);
        if (pick >= 70 && pick < 85)
        begin
            // month ends, first days and edge or out of range day of year
            if ($urandom_range(1))
                bd = age_board::month_days(bm, by);
            else
                bd = 1;
            case ($urandom_range(3))
                0: doy = 0;
                1: doy = 365;
                2: doy = 366;
                default: doy = $urandom_range(511, 367);
            endcase
        end
        else if (pick >= 85)
        begin
            // raw field noise, mostly invalid dates
            by  = $urandom_range(4095, 0);
            bm  = $urandom_range(255, 0);
            bd  = $urandom_range(255, 0);
            cy  = $urandom_range(4095, 0);
            doy = $urandom_range(511, 0);
        end
        send_date(by, bm, bd, cy, doy);
    endtask

    initial
    begin
        board = new;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // invalid birth dates in check order
        send_date(0, 5, 10, 2020, 100);
        send_date(2000, 0, 1, 2020, 1);
        send_date(2000, 13, 1, 2020, 1);
        send_date(4095, 255, 255, 4095, 511);
        send_date(1990, 6, 0, 2020, 50);
        send_date(1990, 4, 31, 2020, 50);
        send_date(1990, 1, 255, 2020, 50);
        send_date(1900, 2, 29, 2020, 50);
        send_date(100, 2, 29, 2020, 50);
        // leap days and century rules
        send_date(2000, 2, 29, 2024, 60);
        send_date(2004, 2, 29, 2023, 59);
        send_date(2400, 2, 29, 2400, 60);
        send_date(400, 2, 29, 500, 1);
        send_date(2000, 3, 1, 2000, 61);
        // day of year zero and past the year end
        send_date(1999, 12, 31, 2023, 0);
        send_date(1999, 3, 15, 2023, 366);
        send_date(1999, 3, 15, 2024, 366);
        send_date(1999, 3, 15, 2100, 511);
        // extremes of the year span and saturation
        send_date(1, 1, 1, 4095, 366);
        send_date(4095, 12, 31, 0, 1);
        send_date(4095, 1, 1, 0, 511);
        send_date(4095, 12, 1, 4095, 335);
        // birth after the current date and day borrows
        send_date(2030, 7, 20, 2023, 150);
        send_date(2023, 5, 31, 2023, 152);
        send_date(1985, 1, 31, 2023, 60);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 600 && i < 900);
            send_random_date();
        end
        calm = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.faults == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
